@@ hw/rtl/dda_pkg.sv @@
package dda_pkg;

    // result status codes
    localparam logic [1:0] STATUS_WALL = 2'd0;
    localparam logic [1:0] STATUS_LEFT = 2'd1;
    localparam logic [1:0] STATUS_ZERO = 2'd2;

    // input word: tile write or ray cast
    typedef struct packed {
        logic               command;
        logic [5:0]         tile_x;
        logic [5:0]         tile_y;
        logic               wall_flag;
        logic [15:0]        pos_x;
        logic [15:0]        pos_y;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic               already_hit;
    } dda_in_t;

    // result word
    typedef struct packed {
        logic [5:0] hit_x;
        logic [5:0] hit_y;
        logic       last_side;
        logic       step_x_negative;
        logic       step_y_negative;
        logic [1:0] status;
    } dda_out_t;

    // controller to datapath commands
    typedef struct packed {
        logic       clear;
        logic       load;
        logic       wr_tile;
        logic       init;
        logic       step;
        logic       capture;
        logic [1:0] code;
    } dda_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic clear_done;
        logic already_hit;
        logic start_out;
        logic zero_dir;
        logic wall_hit;
        logic next_out;
    } dda_sts_t;

endpackage

@@ hw/rtl/dda_datapath.sv @@
module dda_datapath import dda_pkg::*; #(
    parameter int MAP_SIZE = 64
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  dda_in_t  s_data,
    input  dda_cmd_t cmd,
    output dda_sts_t sts,
    output dda_out_t m_data
);

    localparam int DEPTH = MAP_SIZE * MAP_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(MAP_SIZE);
    localparam int CW    = ($clog2(MAP_SIZE + 1) + 1 > 7) ? $clog2(MAP_SIZE + 1) + 1 : 7;

    logic                 wall_mem [DEPTH];

    logic signed [CW-1:0] cell_x_reg, cell_y_reg;
    logic [31:0]          sum_x_reg, sum_y_reg;
    logic [15:0]          mag_x_reg, mag_y_reg;
    logic [9:0]           frac_x_reg, frac_y_reg;
    logic                 sxn_reg, syn_reg;
    logic                 hit_reg;
    logic                 side_reg;
    logic                 rd_pend_reg;
    logic                 rd_wall_reg;
    logic [AW-1:0]        clr_cnt_reg;
    dda_out_t             result_reg;

    logic [15:0]          dx, dy, mag_x, mag_y;
    logic [10:0]          dist_x, dist_y;
    logic [26:0]          prod_x, prod_y;
    logic                 take_x;
    logic signed [CW-1:0] next_x, next_y;
    logic                 next_out;
    logic [AW-1:0]        rd_addr, wr_addr;
    logic                 tile_ok;

    function automatic logic in_map(input logic signed [CW-1:0] c);
        return (c >= 0) && (c < CW'(MAP_SIZE));
    endfunction

    // direction magnitudes of the incoming word
    assign dx    = s_data.dir_x;
    assign dy    = s_data.dir_y;
    assign mag_x = dx[15] ? (~dx + 16'd1) : dx;
    assign mag_y = dy[15] ? (~dy + 16'd1) : dy;

    // starting side distances, scaled by the crossed increment
    assign dist_x = sxn_reg ? {1'b0, frac_x_reg} : (11'd1024 - {1'b0, frac_x_reg});
    assign dist_y = syn_reg ? {1'b0, frac_y_reg} : (11'd1024 - {1'b0, frac_y_reg});
    assign prod_x = 27'(dist_x) * 27'(mag_y_reg);
    assign prod_y = 27'(dist_y) * 27'(mag_x_reg);

    // one dda step: cross the nearer side, ties go to y
    assign take_x = sum_x_reg < sum_y_reg;
    always_comb begin
        next_x = cell_x_reg;
        next_y = cell_y_reg;
        if (take_x) begin
            next_x = sxn_reg ? (cell_x_reg - CW'(1)) : (cell_x_reg + CW'(1));
        end else begin
            next_y = syn_reg ? (cell_y_reg - CW'(1)) : (cell_y_reg + CW'(1));
        end
    end
    assign next_out = !in_map(next_x) || !in_map(next_y);

    // map addresses
    assign rd_addr = AW'(int'(next_x[IW-1:0]) * MAP_SIZE + int'(next_y[IW-1:0]));
    assign wr_addr = AW'(int'(s_data.tile_x) * MAP_SIZE + int'(s_data.tile_y));
    assign tile_ok = (int'(s_data.tile_x) < MAP_SIZE) && (int'(s_data.tile_y) < MAP_SIZE);

    // wall map: one write port, registered read of the cell just stepped to
    always_ff @(posedge aclk) begin
        if (cmd.clear) begin
            wall_mem[clr_cnt_reg] <= 1'b0;
        end else if (cmd.wr_tile && tile_ok) begin
            wall_mem[wr_addr] <= s_data.wall_flag;
        end
        if (cmd.step && !next_out) begin
            rd_wall_reg <= wall_mem[rd_addr];
        end
    end

    // clearing pass counter and outstanding read flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            rd_pend_reg <= 1'b0;
        end else begin
            if (cmd.clear) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.init) begin
                rd_pend_reg <= 1'b0;
            end else if (cmd.step) begin
                rd_pend_reg <= !next_out;
            end
        end
    end

    // walk registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cell_x_reg <= CW'(s_data.pos_x[15:10]);
            cell_y_reg <= CW'(s_data.pos_y[15:10]);
            frac_x_reg <= s_data.pos_x[9:0];
            frac_y_reg <= s_data.pos_y[9:0];
            mag_x_reg  <= mag_x;
            mag_y_reg  <= mag_y;
            sxn_reg    <= dx[15];
            syn_reg    <= dy[15];
            hit_reg    <= s_data.already_hit;
            side_reg   <= 1'b0;
        end
        if (cmd.init) begin
            sum_x_reg <= 32'(prod_x);
            sum_y_reg <= 32'(prod_y);
        end
        if (cmd.step) begin
            cell_x_reg <= next_x;
            cell_y_reg <= next_y;
            if (take_x) begin
                sum_x_reg <= sum_x_reg + 32'(mag_y_reg);
                side_reg  <= 1'b0;
            end else begin
                sum_y_reg <= sum_y_reg + 32'(mag_x_reg);
                side_reg  <= 1'b1;
            end
        end
        if (cmd.capture) begin
            result_reg.hit_x           <= cell_x_reg[5:0];
            result_reg.hit_y           <= cell_y_reg[5:0];
            result_reg.last_side       <= side_reg;
            result_reg.step_x_negative <= sxn_reg;
            result_reg.step_y_negative <= syn_reg;
            result_reg.status          <= cmd.code;
        end
    end

    // status back to the controller
    assign sts.clear_done  = clr_cnt_reg == AW'(DEPTH - 1);
    assign sts.already_hit = hit_reg;
    assign sts.start_out   = !in_map(cell_x_reg) || !in_map(cell_y_reg);
    assign sts.zero_dir    = (mag_x_reg == 16'd0) && (mag_y_reg == 16'd0);
    assign sts.wall_hit    = rd_pend_reg && rd_wall_reg;
    assign sts.next_out    = next_out;

    assign m_data = result_reg;

endmodule

@@ hw/rtl/dda_ctrl.sv @@
module dda_ctrl import dda_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_command,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  dda_sts_t sts,
    output dda_cmd_t cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_INIT  = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [1:0] code_reg, code_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;

    assign s_ready = state_reg == S_IDLE;
    assign accept  = s_valid && s_ready;
    assign m_valid = out_valid_reg;

    // sequencing
    always_comb begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd        = '0;
        cmd.code   = code_reg;
        case (state_reg)
            S_CLEAR: begin
                cmd.clear = 1'b1;
                if (sts.clear_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                cmd.load    = accept && s_command;
                cmd.wr_tile = accept && !s_command;
                if (accept && s_command) begin
                    state_next = S_INIT;
                end
            end
            S_INIT: begin
                cmd.init = 1'b1;
                if (sts.already_hit) begin
                    code_next  = STATUS_WALL;
                    state_next = S_DONE;
                end else if (sts.start_out) begin
                    code_next  = STATUS_LEFT;
                    state_next = S_DONE;
                end else if (sts.zero_dir) begin
                    code_next  = STATUS_ZERO;
                    state_next = S_DONE;
                end else begin
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                if (sts.wall_hit) begin
                    code_next  = STATUS_WALL;
                    state_next = S_DONE;
                end else begin
                    cmd.step = 1'b1;
                    if (sts.next_out) begin
                        code_next  = STATUS_LEFT;
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.capture = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output word valid
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.capture) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            code_reg      <= STATUS_WALL;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            code_reg      <= code_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ hw/rtl/dda_grid_ray_traversal.sv @@
// operation: a tile write is stored when it is accepted; a cast runs an init state, a
// walk of n cells (none for already hit, start off the map and zero direction, at most
// 2*MAP_SIZE) at one dda step per cycle, with a registered map read checked while the
// next step goes out, and a done state that loads the result word
// throughput: one cast at a time, the next word is taken the cycle after the result is
// loaded, later while the previous result word waits for m_ready
// reset: synchronous, active low; then a pass clears every cell of the wall map while
// s_ready stays low
module dda_grid_ray_traversal import dda_pkg::*; #(
    parameter int MAP_SIZE = 64
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dda_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output dda_out_t m_data
);

    dda_cmd_t cmd;
    dda_sts_t sts;

    // sequencer
    dda_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_command (s_data.command),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // map, walk registers and result word
    dda_datapath #(
        .MAP_SIZE (MAP_SIZE)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_data  (m_data)
    );

endmodule

@@ hw/rtl/dda_checker.sv @@
module dda_checker import dda_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input dda_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input dda_out_t m_data
);

    // a stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // status code stays in its defined range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status != 2'd3)
        else $error("undefined status code");

    // a zero direction never walks and has positive step signs
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == STATUS_ZERO |->
            !m_data.last_side && !m_data.step_x_negative && !m_data.step_y_negative)
        else $error("zero direction result malformed");

    // an accepted cast blocks the input while it runs
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.command |=> !s_ready)
        else $error("input taken while a cast runs");

    // map clearing follows reset: nothing taken or shown
    assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("block active right after reset");

endmodule

bind dda_grid_ray_traversal dda_checker u_dda_checker (.*);
